>>> rtl/core/dcmf_pkg.sv
// Shared constants, types and the minimum tree used by the dark channel filter.
package dcmf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_RADIUS = 7;
    localparam int CELLS      = 2 * MAX_RADIUS + 1;
    localparam int STORE_ROWS = CELLS;
    localparam int TREE_N     = 2 ** $clog2(CELLS);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int HI_W       = $clog2(CELLS);
    localparam int PIX_W      = 8;
    localparam int OROW_W     = 12;
    localparam int IROW_W     = 13;
    localparam int WREG_W     = 12;
    localparam int HREG_W     = 13;
    localparam int RREG_W     = 3;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int COL_LIMIT  = 2048;
    localparam int ROW_LIMIT  = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_WINDOW_RADIUS = 2'd2
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    // Frame geometry as used by the datapath, already clamped.
    typedef struct packed {
        logic [COL_W-1:0]  w_m1;
        logic [OROW_W-1:0] h_m1;
        logic [RREG_W-1:0] radius;
    } frame_cfg_t;

    // One column minimum and the output run that it opens.
    typedef struct packed {
        pix_t              colmin;
        logic              first_col;
        logic              emit;
        logic [COL_W-1:0]  start_col;
        logic [COL_W-1:0]  end_col;
        logic [HI_W-1:0]   hi;
        logic [OROW_W-1:0] orow;
        logic              fd;
    } col_item_t;

    // Balanced minimum tree over a power-of-two set of pixels.
    function automatic pix_t tree_min(input pix_t [TREE_N-1:0] v);
        pix_t [TREE_N-1:0] t;
        t = v;
        for (int s = TREE_N >> 1; s >= 1; s = s >> 1) begin
            for (int i = 0; i < s; i++) begin
                t[i] = (t[2*i] < t[2*i+1]) ? t[2*i] : t[2*i+1];
            end
        end
        return t[0];
    endfunction

endpackage

>>> rtl/core/dcmf_pixel_if.sv
// Pixel input channel: valid, ready and one BGR pixel or a drain mark.
interface dcmf_pixel_if;
    logic                valid;
    logic                ready;
    logic [7:0]          blue;
    logic [7:0]          green;
    logic [7:0]          red;
    logic                is_drain;

    modport source (output valid, output blue, output green, output red, output is_drain,
                    input ready);
    modport sink   (input valid, input blue, input green, input red, input is_drain,
                    output ready);
endinterface

>>> rtl/core/dcmf_result_if.sv
// Result output channel: valid, ready and one filtered pixel with its position.
interface dcmf_result_if;
    logic                valid;
    logic                ready;
    logic [7:0]          dark_value;
    logic [10:0]         out_column;
    logic [11:0]         out_row;
    logic                last_of_run;
    logic                frame_done;

    modport source (output valid, output dark_value, output out_column, output out_row,
                    output last_of_run, output frame_done, input ready);
    modport sink   (input valid, input dark_value, input out_column, input out_row,
                    input last_of_run, input frame_done, output ready);
endinterface

>>> rtl/core/dcmf_row_bank.sv
// One row of the line store: one write port and one registered read port.
module dcmf_row_bank (
    input  logic                           clk,
    input  logic                           we,
    input  logic [dcmf_pkg::COL_W-1:0]     waddr,
    input  dcmf_pkg::pix_t                 wdata,
    input  logic                           re,
    input  logic [dcmf_pkg::COL_W-1:0]     raddr,
    output dcmf_pkg::pix_t                 rdata
);

    dcmf_pkg::pix_t mem [dcmf_pkg::MAX_WIDTH];
    dcmf_pkg::pix_t rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/dcmf_column_stage.sv
// Input position tracking, row store and vertical minimum over the window rows.
module dcmf_column_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    dcmf_pixel_if.sink              pix,
    input  dcmf_pkg::frame_cfg_t    cfg,
    input  logic                    restart,
    input  logic                    take,
    output logic                    item_valid,
    output dcmf_pkg::col_item_t     item
);

    localparam int COL_W  = dcmf_pkg::COL_W;
    localparam int IROW_W = dcmf_pkg::IROW_W;
    localparam int OROW_W = dcmf_pkg::OROW_W;
    localparam int SLOT_W = dcmf_pkg::SLOT_W;
    localparam int HI_W   = dcmf_pkg::HI_W;
    localparam int CELLS  = dcmf_pkg::CELLS;
    localparam int NROWS  = dcmf_pkg::STORE_ROWS;
    localparam int TREE_N = dcmf_pkg::TREE_N;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [IROW_W-1:0]   row_reg, row_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    logic                s1_valid_reg;
    dcmf_pkg::pix_t      s1_m_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic [CELLS-1:0]    s1_vmask_reg;
    dcmf_pkg::col_item_t s1_item_reg;
    logic                s2_valid_reg;
    dcmf_pkg::col_item_t s2_item_reg;

    logic                adv, accept, padding, live, wr_en, last_col, w_ge_r;
    logic [COL_W-1:0]    ic;
    logic [HI_W-1:0]     two_r;
    dcmf_pkg::pix_t      m, bg;
    logic [CELLS-1:0]    vmask;
    dcmf_pkg::col_item_t s0_item, s1_full;
    logic [IROW_W:0]     row_inc, frame_rows;
    dcmf_pkg::pix_t      bank_rd [NROWS];

    // Handshake and current position.
    assign adv       = !s2_valid_reg || take;
    assign pix.ready = adv;
    assign accept    = pix.valid && adv;
    assign padding   = row_reg > IROW_W'(cfg.h_m1);
    assign ic        = (col_reg > cfg.w_m1) ? cfg.w_m1 : col_reg;
    assign last_col  = (ic == cfg.w_m1);
    assign live      = accept && !(!padding && pix.is_drain);
    assign wr_en     = live && !padding;
    assign bg        = (pix.blue < pix.green) ? pix.blue : pix.green;
    assign m         = (pix.red < bg) ? pix.red : bg;
    assign two_r     = HI_W'(cfg.radius) + HI_W'(cfg.radius);
    assign w_ge_r    = cfg.w_m1 >= COL_W'(cfg.radius);

    // Which stored rows belong to the vertical window of the output row.
    always_comb
    begin
        for (int k = 0; k < CELLS; k++)
        begin
            if (k == 0)
            begin
                vmask[k] = !padding;
            end
            else
            begin
                vmask[k] = (HI_W'(k) <= two_r) && (IROW_W'(k) <= row_reg) &&
                           ((row_reg - IROW_W'(k)) <= IROW_W'(cfg.h_m1));
            end
        end
    end

    // Output run that this column opens: one result, or the burst at the row end.
    always_comb
    begin
        s0_item           = '0;
        s0_item.first_col = (ic == '0);
        s0_item.orow      = OROW_W'(row_reg - IROW_W'(cfg.radius));
        s0_item.fd        = last_col && (s0_item.orow == cfg.h_m1);
        if (last_col)
        begin
            s0_item.emit      = row_reg >= IROW_W'(cfg.radius);
            s0_item.end_col   = cfg.w_m1;
            s0_item.start_col = w_ge_r ? (cfg.w_m1 - COL_W'(cfg.radius)) : '0;
            s0_item.hi        = w_ge_r ? two_r : (HI_W'(cfg.w_m1) + HI_W'(cfg.radius));
        end
        else
        begin
            s0_item.emit      = (row_reg >= IROW_W'(cfg.radius)) &&
                                (ic >= COL_W'(cfg.radius));
            s0_item.start_col = ic - COL_W'(cfg.radius);
            s0_item.end_col   = ic - COL_W'(cfg.radius);
            s0_item.hi        = two_r;
        end
    end

    // Next input position.
    assign row_inc    = {1'b0, row_reg} + (IROW_W+1)'(1);
    assign frame_rows = (IROW_W+1)'(cfg.h_m1) + (IROW_W+1)'(1) + (IROW_W+1)'(cfg.radius);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
        end
        else if (live)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (row_inc >= frame_rows)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_inc[IROW_W-1:0];
                    slot_next = (slot_reg == SLOT_W'(NROWS - 1)) ? '0 : slot_reg + 1'b1;
                end
            end
            else
            begin
                col_next = ic + 1'b1;
            end
        end
    end

    // Row store, one bank for each row slot.
    for (genvar b = 0; b < NROWS; b++)
    begin : g_bank
        dcmf_row_bank u_bank (
            .clk   (clk),
            .we    (wr_en && (slot_reg == SLOT_W'(b))),
            .waddr (ic),
            .wdata (m),
            .re    (adv),
            .raddr (ic),
            .rdata (bank_rd[b])
        );
    end

    // Vertical minimum: rotate the banks into row age order, mask, reduce.
    always_comb
    begin
        logic [SLOT_W:0]              src;
        dcmf_pkg::pix_t [TREE_N-1:0]  tv;
        tv = '1;
        for (int k = 0; k < CELLS; k++)
        begin
            src = {1'b0, s1_slot_reg} + (SLOT_W+1)'(NROWS - k);
            if (src >= (SLOT_W+1)'(NROWS))
            begin
                src = src - (SLOT_W+1)'(NROWS);
            end
            if (s1_vmask_reg[k])
            begin
                tv[k] = (k == 0) ? s1_m_reg : bank_rd[src[SLOT_W-1:0]];
            end
        end
        s1_full        = s1_item_reg;
        s1_full.colmin = dcmf_pkg::tree_min(tv);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            if (adv)
            begin
                s1_valid_reg <= live;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_m_reg     <= m;
            s1_slot_reg  <= slot_reg;
            s1_vmask_reg <= vmask;
            s1_item_reg  <= s0_item;
            s2_item_reg  <= s1_full;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

>>> rtl/core/dcmf_min_cell.sv
// One cell of the column chain: holds one column minimum and passes it on.
module dcmf_min_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  logic           clear,
    input  dcmf_pkg::pix_t din,
    input  logic           keep,
    output dcmf_pkg::pix_t q,
    output dcmf_pkg::pix_t qm
);

    dcmf_pkg::pix_t val_reg;

    // Shift in the neighbor's value; a new row starts with empty cells.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '1;
        end
        else if (shift)
        begin
            val_reg <= clear ? '1 : din;
        end
    end

    assign q  = val_reg;
    assign qm = keep ? val_reg : '1;

endmodule

>>> rtl/core/dcmf_cell_chain.sv
// Horizontal minimum over the chain of column cells and the result register.
module dcmf_cell_chain (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  dcmf_pkg::col_item_t     item,
    output logic                    take,
    dcmf_result_if.source           res
);

    localparam int COL_W  = dcmf_pkg::COL_W;
    localparam int OROW_W = dcmf_pkg::OROW_W;
    localparam int HI_W   = dcmf_pkg::HI_W;
    localparam int CELLS  = dcmf_pkg::CELLS;
    localparam int TREE_N = dcmf_pkg::TREE_N;

    logic                job_active_reg;
    logic [COL_W-1:0]    job_col_reg, job_end_reg;
    logic [HI_W-1:0]     job_hi_reg;
    logic [OROW_W-1:0]   job_orow_reg;
    logic                job_fd_reg;

    logic                res_valid_reg, res_last_reg, res_fd_reg;
    dcmf_pkg::pix_t      res_dark_reg;
    logic [COL_W-1:0]    res_col_reg;
    logic [OROW_W-1:0]   res_row_reg;

    logic                out_free, emit, final_out, shift;
    dcmf_pkg::pix_t      q  [CELLS];
    dcmf_pkg::pix_t      qm [CELLS];
    dcmf_pkg::pix_t      dark;

    assign out_free  = !res_valid_reg || res.ready;
    assign emit      = job_active_reg && out_free;
    assign final_out = (job_col_reg == job_end_reg);
    assign take      = !job_active_reg || (emit && final_out);
    assign shift     = item_valid && take;

    // The chain of cells; cell k holds the column k places behind the newest.
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        dcmf_min_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .clear ((k != 0) && item.first_col),
            .din   ((k == 0) ? item.colmin : q[(k == 0) ? 0 : k - 1]),
            .keep  (HI_W'(k) <= job_hi_reg),
            .q     (q[k]),
            .qm    (qm[k])
        );
    end

    // Minimum over the cells inside the window.
    always_comb
    begin
        dcmf_pkg::pix_t [TREE_N-1:0] tv;
        tv = '1;
        for (int k = 0; k < CELLS; k++)
        begin
            tv[k] = qm[k];
        end
        dark = dcmf_pkg::tree_min(tv);
    end

    // Run control and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_active_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (shift)
            begin
                job_active_reg <= item.emit;
            end
            else if (emit && final_out)
            begin
                job_active_reg <= 1'b0;
            end
            if (out_free)
            begin
                res_valid_reg <= emit;
            end
        end
    end

    // Run position and result payload.
    always_ff @(posedge clk)
    begin
        if (shift && item.emit)
        begin
            job_col_reg  <= item.start_col;
            job_end_reg  <= item.end_col;
            job_hi_reg   <= item.hi;
            job_orow_reg <= item.orow;
            job_fd_reg   <= item.fd;
        end
        else if (emit)
        begin
            job_col_reg <= job_col_reg + 1'b1;
            job_hi_reg  <= job_hi_reg - 1'b1;
        end
        if (emit)
        begin
            res_dark_reg <= dark;
            res_col_reg  <= job_col_reg;
            res_row_reg  <= job_orow_reg;
            res_last_reg <= final_out;
            res_fd_reg   <= job_fd_reg && final_out;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.dark_value  = res_dark_reg;
    assign res.out_column  = res_col_reg;
    assign res.out_row     = res_row_reg;
    assign res.last_of_run = res_last_reg;
    assign res.frame_done  = res_fd_reg;

    // A run never walks past its last column.
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_active_reg |-> (job_col_reg <= job_end_reg))
        else $error("output run passed its last column");

    // The last result of a run is marked as such.
    a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && final_out) |=> (res_valid_reg && res_last_reg))
        else $error("final result of a run not marked last");

    // The end of a frame always closes a run.
    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_fd_reg) |-> res_last_reg)
        else $error("frame end flagged on a result that is not last of its run");

endmodule

>>> rtl/core/dark_channel_min_filter_unit.sv
// Top level of the dark channel minimum filter with its configuration registers.
//
// Pixels enter on the pix channel in raster order, one transaction each; the
// minimum of blue, green and red is taken and a square minimum filter of side
// 2R+1, clipped at the image edges, is applied. Results leave on the res
// channel, lagging the input by R rows and R columns. After the last pixel of
// a frame, R*W transactions with is_drain set release the last R rows.
// Throughput is one pixel per cycle unless the receiver stalls. The last
// column of a row that produces output gives up to R+1 results, one per cycle
// from the column cell chain, and holds the input until its run is through.
// A pixel reaches the result register through the column stage and the chain.
// When the receiver stalls, the result register holds and the run in the
// cell chain waits; ready falls as soon as the column stage holds a
// transaction that the chain cannot take yet, and the line store stops too.
// Reset clears the position to row 0, column 0 and loads width 640, height
// 480, radius 7; the line store needs no clearing, since a row is always
// written before it is read. A register write restarts the frame position.
module dark_channel_min_filter_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    dcmf_pixel_if.sink                       pix,
    dcmf_result_if.source                    res,
    input  logic                             cfg_write,
    input  logic [dcmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcmf_pkg::CFG_W-1:0]       cfg_data
);

    logic [dcmf_pkg::WREG_W-1:0] image_width_reg;
    logic [dcmf_pkg::HREG_W-1:0] image_height_reg;
    logic [dcmf_pkg::RREG_W-1:0] window_radius_reg;
    logic                        restart;
    dcmf_pkg::frame_cfg_t        cfg;
    logic                        item_valid, take;
    dcmf_pkg::col_item_t         item;

    // Only writes to a known register restart the frame.
    always_comb
    begin
        restart = 1'b0;
        case (cfg_index)
            dcmf_pkg::REG_IMAGE_WIDTH,
            dcmf_pkg::REG_IMAGE_HEIGHT,
            dcmf_pkg::REG_WINDOW_RADIUS: restart = cfg_write;
            default:                     restart = 1'b0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= dcmf_pkg::WREG_W'(640);
            image_height_reg  <= dcmf_pkg::HREG_W'(480);
            window_radius_reg <= dcmf_pkg::RREG_W'(7);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dcmf_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= cfg_data[dcmf_pkg::WREG_W-1:0];
                dcmf_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[dcmf_pkg::HREG_W-1:0];
                dcmf_pkg::REG_WINDOW_RADIUS:
                    window_radius_reg <= cfg_data[dcmf_pkg::RREG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clamp the registers to the supported geometry.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            cfg.w_m1 = '0;
        end
        else if (image_width_reg > dcmf_pkg::WREG_W'(dcmf_pkg::COL_LIMIT))
        begin
            cfg.w_m1 = dcmf_pkg::COL_W'(dcmf_pkg::COL_LIMIT - 1);
        end
        else
        begin
            cfg.w_m1 = dcmf_pkg::COL_W'(image_width_reg - 1'b1);
        end
        if (image_height_reg == '0)
        begin
            cfg.h_m1 = '0;
        end
        else if (image_height_reg > dcmf_pkg::HREG_W'(dcmf_pkg::ROW_LIMIT))
        begin
            cfg.h_m1 = dcmf_pkg::OROW_W'(dcmf_pkg::ROW_LIMIT - 1);
        end
        else
        begin
            cfg.h_m1 = dcmf_pkg::OROW_W'(image_height_reg - 1'b1);
        end
        cfg.radius = (window_radius_reg > dcmf_pkg::RREG_W'(dcmf_pkg::MAX_RADIUS)) ?
                     dcmf_pkg::RREG_W'(dcmf_pkg::MAX_RADIUS) : window_radius_reg;
    end

    dcmf_column_stage u_column (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg        (cfg),
        .restart    (restart),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dcmf_cell_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res        (res)
    );

endmodule

>>> verif/dark_channel_min_filter_unit_test.sv
// Self-checking testbench for the dark channel minimum filter unit.
module dark_channel_min_filter_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Index past the end of the register list; such writes must be ignored.
    localparam logic [dcmf_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [7:0]  dark_value;
        logic [10:0] out_column;
        logic [11:0] out_row;
        logic        last_of_run;
        logic        frame_done;
    } dark_result_t;

    // Scoreboard: tracks the frame position and row history, predicts results.
    class dark_channel_scoreboard;
        logic [7:0]  line_rows [dcmf_pkg::STORE_ROWS][dcmf_pkg::MAX_WIDTH];
        logic [11:0] width_reg;
        logic [12:0] height_reg;
        logic [2:0]  radius_reg;
        int          in_col;
        int          in_row;
        dark_result_t pending [$];
        int          errors;

        function new();
            width_reg  = 12'd640;
            height_reg = 13'd480;
            radius_reg = 3'd7;
            in_col     = 0;
            in_row     = 0;
            errors     = 0;
        endfunction

        function void write_register(logic [dcmf_pkg::CFG_IDX_W-1:0] idx,
                                     logic [dcmf_pkg::CFG_W-1:0] data);
            case (idx)
                dcmf_pkg::REG_IMAGE_WIDTH:   width_reg  = data[11:0];
                dcmf_pkg::REG_IMAGE_HEIGHT:  height_reg = data[12:0];
                dcmf_pkg::REG_WINDOW_RADIUS: radius_reg = data[2:0];
                default:                     return;
            endcase
            in_col = 0;
            in_row = 0;
        endfunction

        function int eff_width();
            int w;
            w = width_reg;
            if (w < 1) w = 1;
            if (w > dcmf_pkg::COL_LIMIT) w = dcmf_pkg::COL_LIMIT;
            return w;
        endfunction

        function int eff_height();
            int h;
            h = height_reg;
            if (h < 1) h = 1;
            if (h > dcmf_pkg::ROW_LIMIT) h = dcmf_pkg::ROW_LIMIT;
            return h;
        endfunction

        // True when the next accepted transaction falls in the padding rows.
        function bit in_padding();
            return in_row >= eff_height();
        endfunction

        // Note one accepted input transaction and queue the results it releases.
        function void note_input(logic [7:0] b, logic [7:0] g, logic [7:0] rd, logic drain);
            int w, h, r, ic, orow, first, last, r0, r1, c0, c1;
            bit padding, last_col, any;
            logic [7:0] m, acc;
            dark_result_t exp_res;
            w = eff_width();
            h = eff_height();
            r = radius_reg;
            padding = in_row >= h;
            if (!padding && drain) return;
            ic = (in_col > w - 1) ? w - 1 : in_col;
            last_col = ic >= w - 1;
            if (!padding) begin
                m = (b < g) ? b : g;
                if (rd < m) m = rd;
                line_rows[in_row % dcmf_pkg::STORE_ROWS][ic] = m;
            end
            if (in_row >= r) begin
                orow = in_row - r;
                any = 1;
                if (!last_col) begin
                    any = ic >= r;
                    first = ic - r;
                    last = first;
                end else begin
                    first = (w - 1 >= r) ? w - 1 - r : 0;
                    last = w - 1;
                end
                if (any) begin
                    for (int c = first; c <= last; c++) begin
                        r0 = (orow >= r) ? orow - r : 0;
                        r1 = (orow + r <= h - 1) ? orow + r : h - 1;
                        c0 = (c >= r) ? c - r : 0;
                        c1 = (c + r <= w - 1) ? c + r : w - 1;
                        acc = 8'hFF;
                        for (int y = r0; y <= r1; y++)
                            for (int x = c0; x <= c1; x++)
                                if (line_rows[y % dcmf_pkg::STORE_ROWS][x] < acc)
                                    acc = line_rows[y % dcmf_pkg::STORE_ROWS][x];
                        exp_res.dark_value  = acc;
                        exp_res.out_column  = c[10:0];
                        exp_res.out_row     = orow[11:0];
                        exp_res.last_of_run = (c == last);
                        exp_res.frame_done  = (orow == h - 1) && (c == w - 1);
                        pending.insert(pending.size(), exp_res);
                    end
                end
            end
            if (last_col) begin
                in_col = 0;
                in_row++;
                if (in_row >= h + r) in_row = 0;
            end else begin
                in_col = ic + 1;
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(dark_result_t got);
            dark_result_t want;
            if (pending.size() == 0) begin
                $error("unexpected result: row %0d column %0d", got.out_row, got.out_column);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.dark_value != want.dark_value) begin
                $error("dark_value: expected %0d, got %0d", want.dark_value, got.dark_value);
                errors++;
            end
            if (got.out_column != want.out_column) begin
                $error("out_column: expected %0d, got %0d", want.out_column, got.out_column);
                errors++;
            end
            if (got.out_row != want.out_row) begin
                $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                errors++;
            end
            if (got.last_of_run != want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
                errors++;
            end
            if (got.frame_done != want.frame_done) begin
                $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [dcmf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dcmf_pkg::CFG_W-1:0] cfg_data;
    bit lazy;
    int pixel_count;
    dark_channel_scoreboard sb;

    dcmf_pixel_if  pix();
    dcmf_result_if res();

    dark_channel_min_filter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix.sink),
        .res       (res.source),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (!lazy) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drive one input transaction, note it when accepted, then idle a while.
    task automatic send_item(logic [7:0] b, logic [7:0] g, logic [7:0] rd, logic drain);
        int gap;
        bit counts;
        counts = !drain || sb.in_padding();
        pix.valid    <= 1'b1;
        pix.blue     <= b;
        pix.green    <= g;
        pix.red      <= rd;
        pix.is_drain <= drain;
        do @(posedge clk); while (!pix.ready);
        sb.note_input(b, g, rd, drain);
        if (counts) pixel_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_pixel();
        send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Wait until every expected result has arrived and the pipe has settled.
    task automatic wait_idle();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write, then the write enable drops again before the task returns.
    task automatic write_reg(logic [dcmf_pkg::CFG_IDX_W-1:0] idx,
                             logic [dcmf_pkg::CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(int w, int h, int r);
        wait_idle();
        write_reg(dcmf_pkg::REG_WINDOW_RADIUS, dcmf_pkg::CFG_W'(r));
        write_reg(dcmf_pkg::REG_IMAGE_HEIGHT, dcmf_pkg::CFG_W'(h));
        write_reg(dcmf_pkg::REG_IMAGE_WIDTH, dcmf_pkg::CFG_W'(w));
    endtask

    // One frame: pixels with stray drain transactions, then the padding rows.
    // With cut set the frame stops early and the next write restarts it.
    task automatic run_frame(bit cut);
        int total;
        int stop_at;
        total = sb.eff_width() * (sb.eff_height() + sb.radius_reg);
        stop_at = cut ? $urandom_range(1, total) : total;
        for (int k = 0; k < stop_at; k++)
        begin
            if (!sb.in_padding() && $urandom_range(0, 9) == 0)
                send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            if (sb.in_padding())
                send_item(8'($urandom), 8'($urandom), 8'($urandom),
                          $urandom_range(0, 3) != 0);
            else
                send_random_pixel();
        end
    endtask

    // Result side: check each accepted transaction, stall at random.
    initial
    begin
        int hold;
        hold = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
                sb.check_result('{res.dark_value, res.out_column, res.out_row,
                                  res.last_of_run, res.frame_done});
            if (hold > 0)
                hold--;
            else if (!lazy)
                res.ready <= 1'b1;
            else
            begin
                res.ready <= ($urandom_range(0, 99) < 70);
                hold = pick_gap();
            end
        end
    end

    // Stimulus.
    initial
    begin
        sb = new();
        lazy = 1'b1;
        pixel_count = 0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= dcmf_pkg::REG_IMAGE_WIDTH;
        cfg_data <= '0;
        pix.valid <= 1'b0;
        pix.blue <= '0;
        pix.green <= '0;
        pix.red <= '0;
        pix.is_drain <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 3x2 frame, radius 1, channel extremes and the odd cases.
        configure(3, 2, 1);
        write_reg(REG_NONE, 13'h1FFF);
        send_item(8'd0, 8'd255, 8'd255, 1'b0);
        send_item(8'd255, 8'd255, 8'd255, 1'b0);
        send_item(8'd255, 8'd7, 8'd200, 1'b1);
        send_item(8'd255, 8'd255, 8'd9, 1'b0);
        send_item(8'd128, 8'd0, 8'd64, 1'b0);
        send_item(8'd255, 8'd255, 8'd255, 1'b0);
        send_item(8'd1, 8'd2, 8'd0, 1'b0);
        // Padding row: one pixel in place of a drain, then true drains.
        send_item(8'd0, 8'd0, 8'd0, 1'b0);
        send_item(8'd0, 8'd0, 8'd0, 1'b1);
        send_item(8'd33, 8'd44, 8'd55, 1'b1);
        // Radius zero with a single-pixel image, from zero-valued registers.
        configure(0, 0, 0);
        run_frame(1'b0);
        run_frame(1'b0);
        // Width and height past the limit, radius zero, no idling; the next
        // write restarts this partial frame.
        lazy = 1'b0;
        configure(12'hFFF, 13'h1FFF, 0);
        for (int k = 0; k < 24; k++) send_random_pixel();
        // Height past the limit on a one-column image, partial frame.
        configure(1, 13'h1FFF, 7);
        for (int k = 0; k < 24; k++) send_random_pixel();
        lazy = 1'b1;

        // Random frames, mostly small and whole, some cut short.
        while (pixel_count < 260)
        begin
            lazy = $urandom_range(0, 5) != 0;
            configure($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, dcmf_pkg::CFG_W'($urandom));
            run_frame($urandom_range(0, 6) == 0);
        end

        lazy = 1'b1;
        wait_idle();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dcmf_pkg.sv
rtl/core/dcmf_pixel_if.sv
rtl/core/dcmf_result_if.sv
rtl/core/dcmf_row_bank.sv
rtl/core/dcmf_column_stage.sv
rtl/core/dcmf_min_cell.sv
rtl/core/dcmf_cell_chain.sv
rtl/core/dark_channel_min_filter_unit.sv
verif/dark_channel_min_filter_unit_test.sv
